### rtl/core/bfn_pkg.sv
// Shared types, constants and sequencer states for the Bellman-Ford block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package bfn_pkg;

	// Default sizes, handed to the top level as parameter defaults.
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_EDGES_DEF    = 2048;

	// Field widths that are fixed by the interface.
	localparam int CFG_W  = 11;
	localparam int VID_W  = 10;
	localparam int WGT_W  = 32;
	localparam int OUT_W  = 48;
	// Distances grow by at most a few times 2^58 at the largest sizes, so 64 bits never wrap.
	localparam int DIST_W = 64;

	localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(2);

	// Saturation limits of the 48-bit result, sign-extended to the distance width.
	localparam logic signed [DIST_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [DIST_W-1:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

	// Request command codes.
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_RUN    = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [VID_W-1:0]        edge_source;
		logic [VID_W-1:0]        edge_target;
		logic signed [WGT_W-1:0] edge_weight;
	} bfn_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] target_distance;
		logic                    unreachable;
		logic                    unbounded;
	} bfn_out_t;

	// One stored edge.
	typedef struct packed {
		logic [VID_W-1:0]        src;
		logic [VID_W-1:0]        dst;
		logic signed [WGT_W-1:0] weight;
	} bfn_edge_t;

	// One vertex record: reached flag, cycle mark and distance.
	typedef struct packed {
		logic                     reached;
		logic                     mark;
		logic signed [DIST_W-1:0] path_cost;
	} bfn_vtx_t;

	// Write-back decision of the relaxation unit.
	typedef struct packed {
		logic     wen;
		bfn_vtx_t entry;
	} bfn_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_FETCH,
		S_READ,
		S_CALC,
		S_UPDATE,
		S_TARGET,
		S_OUT
	} bfn_state_t;

endpackage

`default_nettype wire

### rtl/core/bfn_relax_unit.sv
// Shared relaxation unit: one 64-bit add, then one 64-bit compare and the mark update.
// Depends on bfn_pkg for the vertex record and write-back types.
`default_nettype none

module bfn_relax_unit
	import bfn_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    load,
	input  wire logic                    marking,
	input  wire bfn_vtx_t                vf,
	input  wire bfn_vtx_t                vt,
	input  wire logic signed [WGT_W-1:0] weight,
	output bfn_wr_t                      wr
);

	logic signed [DIST_W-1:0] cand_s1;
	logic                     from_reached_s1;
	logic                     from_mark_s1;
	bfn_vtx_t                 to_s1;
	logic                     better;

	// First step: candidate distance through the edge, with the operands held.
	always_ff @(posedge clk) begin
		if (load) begin
			cand_s1         <= vf.path_cost + DIST_W'(weight);
			from_reached_s1 <= vf.reached;
			from_mark_s1    <= vf.mark;
			to_s1           <= vt;
		end
	end

	// Second step: compare with the head vertex and form the record to write back.
	always_comb begin
		better         = !to_s1.reached || (to_s1.path_cost > cand_s1);
		wr.wen         = from_reached_s1 && (better || (marking && from_mark_s1));
		wr.entry.reached = 1'b1;
		wr.entry.mark  = to_s1.mark || (marking && (better || from_mark_s1));
		wr.entry.path_cost = better ? cand_s1 : to_s1.path_cost;
	end

endmodule

`default_nettype wire

### rtl/core/bellman_ford_negative_cycle.sv
// Top level of the Bellman-Ford search with negative-cycle marking: edge and vertex
// memories, sequencer and result register. Depends on bfn_pkg and bfn_relax_unit.
//
//  channel   signals                           direction  handshake
//  request   start, busy, request (bfn_in_t)   in         taken when start && !busy
//  result    done, result (bfn_out_t)          out        one-cycle strobe on done
//  config    vertex_count_we, _wdata           in         written when we is high
//
// An append request keeps busy low and the next request may follow. A run request
// first clears V vertex records (vertex 0 set as reached), then makes 2V-1 passes
// over the E stored edges through the shared add/compare unit: an edge in range goes
// through the fetch, read, calc and update states, one out of range through fetch and
// read only, and each pass closes in fetch. The target state reads the target vertex
// and the output state registers the result and strobe. Reset clears the edge count
// and the sequencer and sets the vertex count register to two; the result side cannot
// stall, so a result is shown once and is gone.
`default_nettype none

module bellman_ford_negative_cycle
	import bfn_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bfn_in_t          request,
	output logic                  done,
	output bfn_out_t              result,
	input  wire logic             vertex_count_we,
	input  wire logic [CFG_W-1:0] vertex_count_wdata
);

	localparam int VI_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NV_W   = ($clog2(MAX_VERTICES + 1) > CFG_W) ? $clog2(MAX_VERTICES + 1) : CFG_W;
	localparam int NV2_W  = NV_W + 1;
	localparam int RND_W  = $clog2(2 * MAX_VERTICES);
	localparam int EI_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECNT_W = $clog2(MAX_EDGES + 1);

	// Control registers.
	bfn_state_t        state_q, state_d;
	logic [CFG_W-1:0]  vcount_q;
	logic [NV_W-1:0]   nv_q;
	logic [VI_W-1:0]   vlast_q;
	logic [RND_W-1:0]  rnd_last_q;
	logic [RND_W-1:0]  rnd_mark_q;
	logic [RND_W-1:0]  round_q;
	logic [ECNT_W-1:0] ecount_q;
	logic [ECNT_W-1:0] eidx_q;
	logic [VI_W-1:0]   clr_q;
	logic              done_q;
	bfn_out_t          result_q;

	// Memories and their registered read data.
	bfn_edge_t edge_mem [MAX_EDGES];
	bfn_vtx_t  vtx_mem  [MAX_VERTICES];
	bfn_edge_t erd_q;
	bfn_vtx_t  vf_q;
	bfn_vtx_t  vt_q;

	// Sequencer outputs and helpers.
	logic              accept;
	logic              run_start;
	logic              append;
	logic              ewen;
	logic              erd_en;
	logic              vrd_en;
	logic [VI_W-1:0]   vrd_af;
	logic [VI_W-1:0]   vrd_at;
	logic              vwen;
	logic [VI_W-1:0]   vwaddr;
	bfn_vtx_t          vwdata;
	logic              calc_en;
	logic              edge_next;
	logic              marking;
	logic              in_range;
	logic [NV_W-1:0]   src_ext;
	logic [NV_W-1:0]   dst_ext;
	logic [NV_W-1:0]   vc_ext;
	logic [NV_W-1:0]   nv_cl;
	logic [NV2_W-1:0]  twice_nv;
	bfn_wr_t           relax_wr;
	bfn_out_t          result_d;

	assign accept    = start && !busy;
	assign run_start = accept && (request.cmd == CMD_RUN);
	assign append    = accept && (request.cmd == CMD_APPEND);
	assign marking   = (round_q >= rnd_mark_q);
	assign src_ext   = NV_W'(erd_q.src);
	assign dst_ext   = NV_W'(erd_q.dst);
	assign in_range  = (src_ext < nv_q) && (dst_ext < nv_q);

	// Vertex count clamped to the supported range.
	always_comb begin
		vc_ext = NV_W'(vcount_q);
		if (vc_ext < NV_W'(2)) begin
			nv_cl = NV_W'(2);
		end else if (vc_ext > NV_W'(MAX_VERTICES)) begin
			nv_cl = NV_W'(MAX_VERTICES);
		end else begin
			nv_cl = vc_ext;
		end
		twice_nv = {nv_cl, 1'b0};
	end

	// Next state and memory controls.
	always_comb begin
		state_d   = state_q;
		busy      = (state_q != S_IDLE);
		ewen      = append && (ecount_q != ECNT_W'(MAX_EDGES));
		erd_en    = 1'b0;
		vrd_en    = 1'b0;
		vrd_af    = src_ext[VI_W-1:0];
		vrd_at    = dst_ext[VI_W-1:0];
		vwen      = 1'b0;
		vwaddr    = dst_ext[VI_W-1:0];
		vwdata    = relax_wr.entry;
		calc_en   = 1'b0;
		edge_next = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (run_start) begin
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				// Vertex 0 is the source and starts reached at distance zero.
				vwen   = 1'b1;
				vwaddr = clr_q;
				vwdata = '0;
				vwdata.reached = (clr_q == '0);
				if (clr_q == vlast_q) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				priority if (eidx_q != ecount_q) begin
					erd_en  = 1'b1;
					state_d = S_READ;
				end else if (round_q == rnd_last_q) begin
					state_d = S_TARGET;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_READ: begin
				if (in_range) begin
					vrd_en  = 1'b1;
					state_d = S_CALC;
				end else begin
					edge_next = 1'b1;
					state_d   = S_FETCH;
				end
			end
			S_CALC: begin
				calc_en = 1'b1;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				vwen      = relax_wr.wen;
				edge_next = 1'b1;
				state_d   = S_FETCH;
			end
			S_TARGET: begin
				vrd_en  = 1'b1;
				vrd_at  = vlast_q;
				state_d = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result for the target vertex, saturated to the output width.
	always_comb begin
		result_d = '0;
		if (!vt_q.reached) begin
			result_d.unreachable = 1'b1;
		end else if (vt_q.mark) begin
			result_d.unbounded = 1'b1;
		end else if (vt_q.path_cost > OUT_MAX) begin
			result_d.target_distance = OUT_MAX[OUT_W-1:0];
		end else if (vt_q.path_cost < OUT_MIN) begin
			result_d.target_distance = OUT_MIN[OUT_W-1:0];
		end else begin
			result_d.target_distance = vt_q.path_cost[OUT_W-1:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register, edge count and pass counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= VCOUNT_RESET;
			ecount_q   <= '0;
			nv_q       <= NV_W'(2);
			vlast_q    <= '0;
			rnd_last_q <= '0;
			rnd_mark_q <= '0;
			round_q    <= '0;
			eidx_q     <= '0;
			clr_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (state_q == S_OUT);
			if (vertex_count_we) begin
				vcount_q <= vertex_count_wdata;
			end
			if (ewen) begin
				ecount_q <= ecount_q + ECNT_W'(1);
			end
			if (state_q == S_OUT) begin
				ecount_q <= '0;
			end
			if (run_start) begin
				nv_q       <= nv_cl;
				vlast_q    <= VI_W'(nv_cl - NV_W'(1));
				rnd_last_q <= RND_W'(twice_nv - NV2_W'(2));
				rnd_mark_q <= RND_W'(nv_cl - NV_W'(1));
				round_q    <= '0;
				eidx_q     <= '0;
				clr_q      <= '0;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + VI_W'(1);
			end
			// Closing a pass starts the next one from the first edge.
			if ((state_q == S_FETCH) && (eidx_q == ecount_q) && (round_q != rnd_last_q)) begin
				round_q <= round_q + RND_W'(1);
				eidx_q  <= '0;
			end
			if (edge_next) begin
				eidx_q <= eidx_q + ECNT_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			result_q <= result_d;
		end
	end

	// Edge memory: appended at the fill count, read back in order during a run.
	always_ff @(posedge clk) begin
		if (ewen) begin
			edge_mem[ecount_q[EI_W-1:0]] <= '{
				src:    request.edge_source,
				dst:    request.edge_target,
				weight: request.edge_weight
			};
		end
		if (erd_en) begin
			erd_q <= edge_mem[eidx_q[EI_W-1:0]];
		end
	end

	// Vertex memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (vwen) begin
			vtx_mem[vwaddr] <= vwdata;
		end
		if (vrd_en) begin
			vf_q <= vtx_mem[vrd_af];
			vt_q <= vtx_mem[vrd_at];
		end
	end

	bfn_relax_unit u_relax (
		.clk     (clk),
		.load    (calc_en),
		.marking (marking),
		.vf      (vf_q),
		.vt      (vt_q),
		.weight  (erd_q.weight),
		.wr      (relax_wr)
	);

	assign done   = done_q;
	assign result = result_q;

	// The strobe follows the output state and nothing else.
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_OUT))
		else $error("result strobe without a finished run");

	// A result never claims both an unreachable and an unbounded target.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.unreachable && result_q.unbounded))
		else $error("result flags both set");

	// The edge count is back at zero when the result is shown.
	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (ecount_q == '0))
		else $error("edge count not cleared after a run");

	// The fill count stays within the edge memory.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecount_q <= ECNT_W'(MAX_EDGES))
		else $error("edge count beyond the edge memory");

	// Relaxation writes only touch vertices in use.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vwen && (state_q == S_UPDATE)) |-> (NV_W'(vwaddr) < nv_q))
		else $error("vertex write outside the vertex range");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bellman_ford_negative_cycle: edge and run requests go in,
// and every search result is checked against a shortest-path predictor kept in the bench.
// Depends on bfn_pkg and the RTL in rtl/core; needs no other file.

module tb;
	import bfn_pkg::*;

	localparam int VERTEX_LIMIT    = MAX_VERTICES_DEF;
	localparam int EDGE_LIMIT      = MAX_EDGES_DEF;
	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam int RANDOM_REQUESTS = 1550;
	localparam int RANDOM_PHASES   = 9;
	localparam longint ACC_LIMIT   = 64'sh4000_0000_0000_0000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	bfn_in_t          request;
	logic             done;
	bfn_out_t         result;
	logic             vertex_count_we;
	logic [CFG_W-1:0] vertex_count_wdata;

	// Requests waiting to be offered, and search results still to come.
	bfn_in_t  pending_requests[$];
	bfn_out_t expected_results[$];
	bit       offer_taken;
	int       sender_idle_pct;
	int       error_count;
	int       cycle_count;

	// Shortest-path predictor state.
	bfn_edge_t        edge_list[EDGE_LIMIT];
	int               edge_total;
	longint           vtx_dist[VERTEX_LIMIT];
	bit               vtx_reached[VERTEX_LIMIT];
	bit               vtx_marked[VERTEX_LIMIT];
	logic [CFG_W-1:0] vertex_setting;

	bellman_ford_negative_cycle i_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.done,
		.result,
		.vertex_count_we,
		.vertex_count_wdata
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The register is clamped into the range of the vertex memory.
	function automatic int effective_vertices(logic [CFG_W-1:0] setting);
		if (setting < 2)
			return 2;
		if (setting > VERTEX_LIMIT)
			return VERTEX_LIMIT;
		return int'(setting);
	endfunction

	// One pass over the stored edges; cycle marks spread only in the marking passes.
	function automatic void relax_pass(int nv, bit marking);
		int     src;
		int     dst;
		longint cand;
		for (int j = 0; j < edge_total; j++) begin
			src = int'(edge_list[j].src);
			dst = int'(edge_list[j].dst);
			if (src >= nv || dst >= nv || !vtx_reached[src])
				continue;
			cand = vtx_dist[src] + longint'(edge_list[j].weight);
			if (cand > ACC_LIMIT)
				cand = ACC_LIMIT;
			if (cand < -ACC_LIMIT)
				cand = -ACC_LIMIT;
			if (!vtx_reached[dst] || vtx_dist[dst] > cand) begin
				vtx_dist[dst]    = cand;
				vtx_reached[dst] = 1'b1;
				if (marking)
					vtx_marked[dst] = 1'b1;
			end
			if (marking && vtx_marked[src])
				vtx_marked[dst] = 1'b1;
		end
	endfunction

	// Full search from vertex 0; the edge list is emptied afterwards.
	function automatic bfn_out_t shortest_path_result();
		int       nv;
		longint   d;
		bfn_out_t r;
		nv = effective_vertices(vertex_setting);
		for (int i = 0; i < VERTEX_LIMIT; i++) begin
			vtx_dist[i]    = 0;
			vtx_reached[i] = 1'b0;
			vtx_marked[i]  = 1'b0;
		end
		vtx_reached[0] = 1'b1;
		for (int i = 0; i < nv - 1; i++)
			relax_pass(nv, 1'b0);
		for (int i = 0; i < nv; i++)
			relax_pass(nv, 1'b1);
		r = '0;
		if (!vtx_reached[nv-1]) begin
			r.unreachable = 1'b1;
		end else if (vtx_marked[nv-1]) begin
			r.unbounded = 1'b1;
		end else begin
			d = vtx_dist[nv-1];
			if (d > OUT_MAX)
				d = OUT_MAX;
			if (d < OUT_MIN)
				d = OUT_MIN;
			r.target_distance = d[OUT_W-1:0];
		end
		edge_total = 0;
		return r;
	endfunction

	// Monitor: checks results first, then records an accepted request in the predictor.
	always @(posedge clk) begin
		bfn_out_t want;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("search result with no run request waiting for one");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.target_distance !== want.target_distance) begin
						$error("target_distance: expected %0d, got %0d",
							want.target_distance, result.target_distance);
						error_count++;
					end
					if (result.unreachable !== want.unreachable) begin
						$error("unreachable: expected %0d, got %0d",
							want.unreachable, result.unreachable);
						error_count++;
					end
					if (result.unbounded !== want.unbounded) begin
						$error("unbounded: expected %0d, got %0d",
							want.unbounded, result.unbounded);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				offer_taken = 1'b1;
				if (request.cmd == CMD_APPEND) begin
					if (edge_total < EDGE_LIMIT) begin
						edge_list[edge_total].src    = request.edge_source;
						edge_list[edge_total].dst    = request.edge_target;
						edge_list[edge_total].weight = request.edge_weight;
						edge_total++;
					end
				end else begin
					expected_results = {expected_results, shortest_path_result()};
				end
			end
		end
	end

	// Driver: offers the oldest pending request, with random idle cycles in between.
	always @(negedge clk) begin
		logic [63:0] noise;
		if (offer_taken) begin
			pending_requests.delete(0);
			offer_taken = 1'b0;
		end
		noise = {$urandom, $urandom};
		if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
			start   <= 1'b1;
			request <= pending_requests[0];
		end else begin
			start   <= 1'b0;
			request <= noise[$bits(bfn_in_t)-1:0];
		end
	end

	task automatic add_edge(int src, int dst, logic [WGT_W-1:0] weight);
		bfn_in_t r;
		r.cmd         = CMD_APPEND;
		r.edge_source = src[VID_W-1:0];
		r.edge_target = dst[VID_W-1:0];
		r.edge_weight = weight;
		pending_requests = {pending_requests, r};
	endtask

	// A run request carries random values in the fields it does not use.
	task automatic add_run();
		logic [63:0] noise;
		bfn_in_t     r;
		noise = {$urandom, $urandom};
		r     = noise[$bits(bfn_in_t)-1:0];
		r.cmd = CMD_RUN;
		pending_requests = {pending_requests, r};
	endtask

	// Mostly small weights so that negative cycles turn up, now and then any 32-bit value.
	function automatic logic [WGT_W-1:0] pick_weight();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, 40) - 10;
	endfunction

	// Random edges among the vertices in use, with the odd one anywhere in the id range.
	task automatic add_side_edges(int nv, int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 7) == 0)
				add_edge($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
			else
				add_edge($urandom_range(0, nv - 1), $urandom_range(0, nv - 1), pick_weight());
		end
	endtask

	// One graph and its run request: usually a path towards the target with side edges,
	// otherwise random noise edges.
	task automatic random_graph(int nv, output int count);
		int hops;
		int prev;
		int nxt;
		int n_before;
		int n_after;
		count = 0;
		if ($urandom_range(0, 99) < 80) begin
			n_before = $urandom_range(0, 3);
			n_after  = $urandom_range(0, 3);
			add_side_edges(nv, n_before);
			hops = $urandom_range(0, (nv > 4) ? 3 : nv - 2);
			prev = 0;
			for (int h = 0; h < hops; h++) begin
				nxt = $urandom_range(1, nv - 1);
				add_edge(prev, nxt, pick_weight());
				prev = nxt;
			end
			// Leave the last hop out now and then, so that the target stays unreached.
			if ($urandom_range(0, 9) != 0) begin
				add_edge(prev, nv - 1, pick_weight());
				count++;
			end
			add_side_edges(nv, n_after);
			count += hops + n_before + n_after;
		end else begin
			n_before = $urandom_range(0, 8);
			for (int k = 0; k < n_before; k++)
				add_edge($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
			count = n_before;
		end
		add_run();
		count++;
	endtask

	// Holds the sender back until every request is through and the block has settled.
	task automatic drain();
		while (pending_requests.size() != 0 || expected_results.size() != 0 || start || busy)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_vertices(int value);
		drain();
		@(negedge clk);
		vertex_count_we    <= 1'b1;
		vertex_count_wdata <= CFG_W'(value);
		vertex_setting = CFG_W'(value);
		@(negedge clk);
		vertex_count_we <= 1'b0;
	endtask

	initial begin
		int count;
		int total;
		int pick;
		arst_n             = 1'b0;
		start              = 1'b0;
		request            = '0;
		vertex_count_we    = 1'b0;
		vertex_count_wdata = '0;
		vertex_setting     = VCOUNT_RESET;
		sender_idle_pct    = 0;
		error_count        = 0;
		cycle_count        = 0;
		edge_total         = 0;
		offer_taken        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two vertices after reset: no edges, extreme weights, an ignored edge, a cycle.
		add_run();
		add_edge(0, 1, 32'h8000_0000);
		add_run();
		add_edge(0, 1, 32'h7FFF_FFFF);
		add_edge(1023, 1023, 32'h7FFF_FFFF);
		add_run();
		add_edge(0, 1, 5);
		add_edge(1, 0, -6);
		add_run();

		// Register values below two act as two.
		write_vertices(0);
		add_edge(0, 1, 0);
		add_run();
		write_vertices(1);
		add_run();

		// Values above the vertex memory act as its size.
		write_vertices(11'h7FF);
		add_edge(0, 1023, 7);
		add_edge(0, 5, -3);
		add_edge(5, 1023, 1);
		add_run();
		write_vertices(1024);
		add_edge(0, 512, 1);
		add_run();

		// A negative cycle off the path to the target, then one that leads on to it.
		write_vertices(3);
		add_edge(0, 1, 1);
		add_edge(1, 1, -1);
		add_edge(0, 2, 4);
		add_run();
		add_edge(0, 1, 1);
		add_edge(1, 1, -1);
		add_edge(1, 2, 0);
		add_run();

		// Random graphs under light sender idling, heavy idling, then none.
		for (int mode = 0; mode < 3; mode++) begin
			for (int ph = 0; ph < RANDOM_PHASES / 3; ph++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					write_vertices($urandom_range(0, 1));
				else if (pick < 93)
					write_vertices($urandom_range(2, 10));
				else
					write_vertices($urandom_range(11, 40));
				sender_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 81 : 0;
				total = 0;
				while (total < RANDOM_REQUESTS / RANDOM_PHASES) begin
					random_graph(effective_vertices(vertex_setting), count);
					total += count;
					if ($urandom_range(0, 39) == 0)
						drain();
				end
			end
		end

		drain();
		if (error_count == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
